// ===== sv/glcap_pkg.sv =====
// shared codes and types for the growable list block
// no dependencies; imported by every module of the block
package glcap_pkg;

    // request operation codes
    localparam logic [2:0] OP_APPEND = 3'd0;
    localparam logic [2:0] OP_GET    = 3'd1;
    localparam logic [2:0] OP_SET    = 3'd2;
    localparam logic [2:0] OP_INSERT = 3'd3;
    localparam logic [2:0] OP_POP    = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    // response status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // width of the external position and length fields
    localparam int POS_W = 11;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic write;   // overwrite the cell at the selected index
        logic insert;  // write at the selected index, move later cells up
        logic load;    // load the read chain from the selected cell
    } cell_cmd_t;

endpackage

// ===== sv/glcap_cell.sv =====
// one element cell of the list chain: element register plus one read-chain stage
// depends on glcap_pkg for the cell command struct
module glcap_cell
    import glcap_pkg::*;
#(
    parameter int EW  = 32,
    parameter int LW  = 11,
    parameter int IDX = 0
)
(
    input  logic          clk,
    input  cell_cmd_t     cmd,
    input  logic [LW-1:0] sel_idx,
    input  logic [LW-1:0] bound,
    input  logic [EW-1:0] wdata,
    input  logic [EW-1:0] prev_data,
    input  logic [EW-1:0] chain_in,
    output logic [EW-1:0] data,
    output logic [EW-1:0] chain_out
);

    localparam logic [LW-1:0] MY_IDX = LW'(IDX);

    logic [EW-1:0] data_reg;
    logic [EW-1:0] data_next;
    logic [EW-1:0] chain_reg;
    logic [EW-1:0] chain_next;
    logic          hit;
    logic          in_span;

    // index decode for this cell
    assign hit     = (sel_idx == MY_IDX);
    assign in_span = (MY_IDX > sel_idx) && (MY_IDX <= bound);

    // element update: direct write, or take the lower neighbor on insert
    always_comb
    begin
        data_next = data_reg;
        if ((cmd.write || cmd.insert) && hit)
        begin
            data_next = wdata;
        end
        else if (cmd.insert && in_span)
        begin
            data_next = prev_data;
        end
    end

    // read chain: load the selected element, otherwise move one cell down
    always_comb
    begin
        if (cmd.load)
        begin
            chain_next = hit ? data_reg : '0;
        end
        else
        begin
            chain_next = chain_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        chain_reg <= chain_next;
    end

    assign data      = data_reg;
    assign chain_out = chain_reg;

endmodule

// ===== sv/glcap_policy.sv =====
// capacity rule: keep, grow with over-allocation, shrink, or zero when empty
// depends on glcap_pkg (imported for consistency of the block)
module glcap_policy
    import glcap_pkg::*;
#(
    parameter int LW = 11,
    parameter int CW = 11
)
(
    input  logic [LW-1:0] cur_len,
    input  logic [CW-1:0] cur_cap,
    input  logic [LW-1:0] new_len,
    output logic [CW-1:0] new_cap
);

    logic [CW-1:0] n_x;
    logic [CW-1:0] grow_sum;
    logic [CW-1:0] shrink_sum;
    logic          keep;

    assign n_x        = CW'(new_len);
    assign keep       = (cur_cap >= n_x) && (n_x >= (cur_cap >> 1));
    assign grow_sum   = n_x + (n_x >> 3) + CW'(6);
    assign shrink_sum = n_x + CW'(3);

    // pick the capacity for the new length
    always_comb
    begin
        if (keep)
        begin
            new_cap = cur_cap;
        end
        else if (new_len == '0)
        begin
            new_cap = '0;
        end
        else if (new_len > cur_len)
        begin
            new_cap = {grow_sum[CW-1:2], 2'b00};
        end
        else
        begin
            new_cap = {shrink_sum[CW-1:2], 2'b00};
        end
    end

endmodule

// ===== sv/growable_list_with_capacity_policy.sv =====
// growable list: append, set, insert, clear and errors answer in the cycle after the beat.
// get and pop answer once the selected element has reached cell zero:
// the element walks down the read chain of the cells one cell per cycle.
// a new request beat is taken each cycle while no read walk runs and the response
// register is free or drained in that cycle. reset clears length and capacity;
// element contents stay undefined until written, with no clearing pass.
module growable_list_with_capacity_policy
    import glcap_pkg::*;
#(
    parameter int DEPTH         = 1024,
    parameter int ELEMENT_WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [2:0]        operation,
    input  logic [POS_W-1:0]  position,
    input  logic [31:0]       element_in,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic [1:0]        status,
    output logic [31:0]       element_out,
    output logic [POS_W-1:0]  length_now,
    output logic [POS_W-1:0]  capacity_now
);

    localparam int EW   = ELEMENT_WIDTH;
    localparam int LW   = $clog2(DEPTH + 1);
    localparam int CW   = $clog2(DEPTH + DEPTH / 8 + 8);
    localparam int CMPW = (LW > POS_W) ? LW : POS_W;
    localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic             state_reg, state_next;
    logic [LW-1:0]    cnt_reg, cnt_next;
    logic [LW-1:0]    len_reg, len_next;
    logic [CW-1:0]    cap_reg, cap_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [1:0]       status_reg, status_next;
    logic [31:0]      elem_out_reg, elem_out_next;
    logic [POS_W-1:0] len_out_reg, len_out_next;
    logic [POS_W-1:0] cap_out_reg, cap_out_next;

    logic             accept;
    logic [CMPW-1:0]  pos_x;
    logic [CMPW-1:0]  len_x;
    logic             full;
    logic [LW-1:0]    pos_l;
    logic [LW-1:0]    n_new;
    logic [CW-1:0]    cap_rule;
    logic             resize;
    logic [63:0]      in_wide;
    logic [63:0]      out_wide;
    logic [EW-1:0]    wdata;
    cell_cmd_t        cmd;
    logic [LW-1:0]    sel_idx;

    logic [EW-1:0]    cell_data  [DEPTH];
    logic [EW-1:0]    chain      [DEPTH+1];

    assign accept  = req_valid && req_ready;
    assign pos_x   = CMPW'(position);
    assign len_x   = CMPW'(len_reg);
    assign pos_l   = LW'(position);
    assign full    = (len_reg >= DEPTH_L);
    assign in_wide = 64'(element_in);
    assign wdata   = in_wide[EW-1:0];

    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);

    // new length proposed by a growing or shrinking request
    always_comb
    begin
        if (operation == OP_POP)
        begin
            n_new = len_reg - LW'(1);
        end
        else
        begin
            n_new = len_reg + LW'(1);
        end
    end

    glcap_policy #(
        .LW (LW),
        .CW (CW)
    ) u_policy (
        .cur_len (len_reg),
        .cur_cap (cap_reg),
        .new_len (n_new),
        .new_cap (cap_rule)
    );

    // request decode, list state update and response loading
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        cap_next       = cap_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        elem_out_next  = elem_out_reg;
        cmd            = '0;
        sel_idx        = pos_l;
        resize         = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next    = ST_OK;
                    elem_out_next  = '0;
                    rsp_valid_next = 1'b1;
                    case (operation)
                        OP_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                cmd.write = 1'b1;
                                sel_idx   = len_reg;
                                resize    = 1'b1;
                            end
                        end
                        OP_GET:
                        begin
                            if (pos_x >= len_x)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                cmd.load       = 1'b1;
                                cnt_next       = pos_l;
                                state_next     = S_WALK;
                                rsp_valid_next = 1'b0;
                            end
                        end
                        OP_SET:
                        begin
                            if (pos_x >= len_x)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                cmd.write = 1'b1;
                            end
                        end
                        OP_INSERT:
                        begin
                            if (pos_x > len_x)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                cmd.insert = 1'b1;
                                resize     = 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (len_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.load       = 1'b1;
                                sel_idx        = n_new;
                                cnt_next       = n_new;
                                resize         = 1'b1;
                                state_next     = S_WALK;
                                rsp_valid_next = 1'b0;
                            end
                        end
                        OP_CLEAR:
                        begin
                            len_next = '0;
                            cap_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (resize)
                    begin
                        len_next = n_new;
                        cap_next = cap_rule;
                    end
                end
            end
            S_WALK:
            begin
                // the selected element reaches cell zero when the count runs out
                if (cnt_reg == '0)
                begin
                    elem_out_next  = out_wide[31:0];
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - LW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign len_out_next = accept ? POS_W'(len_next) : len_out_reg;
    assign cap_out_next = accept ? POS_W'(cap_next) : cap_out_reg;
    assign out_wide     = 64'(chain[0]);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            len_reg       <= '0;
            cap_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            len_reg       <= len_next;
            cap_reg       <= cap_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        elem_out_reg <= elem_out_next;
        len_out_reg  <= len_out_next;
        cap_out_reg  <= cap_out_next;
    end

    // chain of element cells; the read chain runs toward cell zero
    assign chain[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [EW-1:0] prev;
        if (i == 0)
        begin : g_first
            assign prev = '0;
        end
        else
        begin : g_rest
            assign prev = cell_data[i-1];
        end

        glcap_cell #(
            .EW  (EW),
            .LW  (LW),
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .sel_idx   (sel_idx),
            .bound     (len_reg),
            .wdata     (wdata),
            .prev_data (prev),
            .chain_in  (chain[i+1]),
            .data      (cell_data[i]),
            .chain_out (chain[i])
        );
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign element_out  = elem_out_reg;
    assign length_now   = len_out_reg;
    assign capacity_now = cap_out_reg;

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for growable_list_with_capacity_policy: directed table and
// random list traffic, every response checked against a typed row or an in-bench list predictor
// depends on glcap_pkg and the growable_list_with_capacity_policy module
`timescale 1ns / 100ps

module tb_top
    import glcap_pkg::*;
();

    localparam int          LIST_DEPTH     = 1024;
    localparam int          RANDOM_BEATS   = 425;
    localparam int          RX_HOLD_CYCLES = 64;
    localparam int          SETTLE_CYCLES  = 40;
    localparam int          CYCLE_LIMIT    = 1000000;
    localparam int          MAX_REPORTS    = 40;
    localparam logic [2:0]  OP_SPARE6      = 3'd6;
    localparam logic [2:0]  OP_SPARE7      = 3'd7;
    localparam logic [10:0] POS_TOP        = 11'd1024;

    // one response beat as the block reports it
    typedef struct packed {
        logic [1:0]  rc;
        logic [31:0] elem;
        logic [10:0] len;
        logic [10:0] cap;
    } list_rsp_t;

    // one row of the directed table
    typedef struct packed {
        logic [2:0]  opcode;
        logic [10:0] pos;
        logic [31:0] elem;
        logic        typed;
        list_rsp_t   want;
    } dir_row_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        req_valid    = 1'b0;
    logic        req_ready;
    logic [2:0]  operation    = OP_APPEND;
    logic [10:0] position     = '0;
    logic [31:0] element_in   = '0;
    logic        rsp_valid;
    logic        rsp_ready    = 1'b0;
    logic [1:0]  status;
    logic [31:0] element_out;
    logic [10:0] length_now;
    logic [10:0] capacity_now;

    // list contents and bookkeeping as the block should hold them
    logic [31:0] shadow_elems [LIST_DEPTH];
    int unsigned shadow_len   = 0;
    int unsigned shadow_cap   = 0;
    int unsigned peak_len     = 0;

    list_rsp_t   pending_rsp [$];
    dir_row_t    directed_rows [25];

    int unsigned beats_sent   = 0;
    int unsigned rsp_checked  = 0;
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;
    int unsigned hold_left    = 0;
    bit          hold_rx_req  = 1'b0;
    bit          no_idle      = 1'b0;

    growable_list_with_capacity_policy #(
        .DEPTH         (LIST_DEPTH),
        .ELEMENT_WIDTH (32)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .operation    (operation),
        .position     (position),
        .element_in   (element_in),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .status       (status),
        .element_out  (element_out),
        .length_now   (length_now),
        .capacity_now (capacity_now)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d responses still pending",
                     cycle_count, pending_rsp.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // capacity after the length moves from old_len to n
    function automatic int unsigned resized_capacity(input int unsigned n,
                                                     input int unsigned old_len,
                                                     input int unsigned cap);
        if (cap >= n && n >= (cap >> 1))
            return cap;
        if (n == 0)
            return 0;
        if (n > old_len)
            return (n + (n >> 3) + 6) & ~32'd3;
        return (n + 3) & ~32'd3;
    endfunction

    // apply one request to the shadow list and return the response it must give
    function automatic list_rsp_t apply_list_request(input logic [2:0] op,
                                                     input logic [10:0] pos,
                                                     input logic [31:0] elem);
        list_rsp_t   rsp;
        int unsigned p;
        p   = 32'(pos);
        rsp = '0;
        rsp.rc = ST_OK;
        case (op)
            OP_APPEND:
            begin
                if (shadow_len >= LIST_DEPTH)
                    rsp.rc = ST_FULL;
                else
                begin
                    shadow_elems[shadow_len] = elem;
                    shadow_cap = resized_capacity(shadow_len + 1, shadow_len, shadow_cap);
                    shadow_len++;
                end
            end
            OP_GET:
            begin
                if (p >= shadow_len)
                    rsp.rc = ST_RANGE;
                else
                    rsp.elem = shadow_elems[p];
            end
            OP_SET:
            begin
                if (p >= shadow_len)
                    rsp.rc = ST_RANGE;
                else
                    shadow_elems[p] = elem;
            end
            OP_INSERT:
            begin
                if (p > shadow_len)
                    rsp.rc = ST_RANGE;
                else if (shadow_len >= LIST_DEPTH)
                    rsp.rc = ST_FULL;
                else
                begin
                    // later elements move up one place
                    for (int i = shadow_len; i > p; i--)
                        shadow_elems[i] = shadow_elems[i-1];
                    shadow_elems[p] = elem;
                    shadow_cap = resized_capacity(shadow_len + 1, shadow_len, shadow_cap);
                    shadow_len++;
                end
            end
            OP_POP:
            begin
                if (shadow_len == 0)
                    rsp.rc = ST_EMPTY;
                else
                begin
                    rsp.elem   = shadow_elems[shadow_len-1];
                    shadow_cap = resized_capacity(shadow_len - 1, shadow_len, shadow_cap);
                    shadow_len--;
                end
            end
            OP_CLEAR:
            begin
                shadow_len = 0;
                shadow_cap = 0;
            end
            default:
            begin
                // spare codes leave everything alone
            end
        endcase
        if (shadow_len > peak_len)
            peak_len = shadow_len;
        rsp.len = shadow_len[10:0];
        rsp.cap = shadow_cap[10:0];
        return rsp;
    endfunction

    function automatic logic [31:0] pick_element();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return '1;
        return $urandom();
    endfunction

    task automatic log_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s at response %0d: got %h, want %h",
                     what, rsp_checked, got, want);
    endtask

    // offer one request beat, with a random gap ahead of it
    task automatic send_request(input logic [2:0] op, input logic [10:0] pos,
                                input logic [31:0] elem, input logic typed,
                                input list_rsp_t typed_rsp);
        list_rsp_t predicted;
        while (!no_idle && $urandom_range(0, 99) < 21)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        predicted = apply_list_request(op, pos, elem);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
        req_valid  <= 1'b1;
        operation  <= op;
        position   <= pos;
        element_in <= elem;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        beats_sent++;
    endtask

    // lower valid and wait until every pending response has come back
    task automatic drain_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    // response side: random stalls, one long hold-off on request
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_rx_req)
            begin
                hold_rx_req = 1'b0;
                hold_left   = RX_HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= no_idle || ($urandom_range(0, 99) >= 21);
            @(posedge clk);
        end
    end

    // response checker
    always @(posedge clk)
    begin
        list_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
                log_mismatch("unexpected response beat", {30'd0, status}, 32'd0);
            else
            begin
                want = pending_rsp.pop_front();
                if (status !== want.rc)
                    log_mismatch("status", {30'd0, status}, {30'd0, want.rc});
                if (element_out !== want.elem)
                    log_mismatch("element_out", element_out, want.elem);
                if (length_now !== want.len)
                    log_mismatch("length_now", {21'd0, length_now}, {21'd0, want.len});
                if (capacity_now !== want.cap)
                    log_mismatch("capacity_now", {21'd0, capacity_now}, {21'd0, want.cap});
            end
            rsp_checked++;
        end
    end

    // stimulus
    initial
    begin
        int unsigned len_goal;
        int unsigned r;
        logic [2:0]  op;
        logic [10:0] pos;
        logic [31:0] elem;

        // typed responses where the outcome is plain, predictor elsewhere
        directed_rows = '{
            '{OP_POP,    11'd0,    32'd0,        1'b1, '{ST_EMPTY, 32'd0, 11'd0, 11'd0}},
            '{OP_GET,    11'd0,    32'd0,        1'b1, '{ST_RANGE, 32'd0, 11'd0, 11'd0}},
            '{OP_SET,    11'd0,    32'h1234_5678, 1'b1, '{ST_RANGE, 32'd0, 11'd0, 11'd0}},
            '{OP_INSERT, 11'd1,    32'h1234_5678, 1'b1, '{ST_RANGE, 32'd0, 11'd0, 11'd0}},
            '{OP_SPARE6, 11'd3,    32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'd0, 11'd0, 11'd0}},
            '{OP_SPARE7, 11'd0,    32'd0,        1'b1, '{ST_OK,    32'd0, 11'd0, 11'd0}},
            '{OP_INSERT, 11'd0,    32'hFFFF_FFFF, 1'b1, '{ST_OK,    32'd0, 11'd1, 11'd4}},
            '{OP_APPEND, 11'd0,    32'd0,        1'b1, '{ST_OK,    32'd0, 11'd2, 11'd4}},
            '{OP_APPEND, 11'd0,    32'hA5A5_A5A5, 1'b0, '0},
            '{OP_INSERT, 11'd3,    32'h5A5A_5A5A, 1'b0, '0},
            '{OP_INSERT, 11'd1,    32'd1,        1'b0, '0},
            '{OP_GET,    11'd0,    32'd0,        1'b0, '0},
            '{OP_GET,    11'd4,    32'd0,        1'b0, '0},
            '{OP_GET,    11'd5,    32'd0,        1'b1, '{ST_RANGE, 32'd0, 11'd5, 11'd8}},
            '{OP_SET,    11'd2,    32'h8000_0000, 1'b0, '0},
            '{OP_GET,    11'd2,    32'd0,        1'b0, '0},
            '{OP_SET,    11'd5,    32'h0000_0001, 1'b1, '{ST_RANGE, 32'd0, 11'd5, 11'd8}},
            '{OP_INSERT, 11'd6,    32'h0000_0002, 1'b1, '{ST_RANGE, 32'd0, 11'd5, 11'd8}},
            '{OP_POP,    11'd0,    32'd0,        1'b0, '0},
            '{OP_POP,    11'd0,    32'd0,        1'b0, '0},
            '{OP_CLEAR,  11'd0,    32'd0,        1'b1, '{ST_OK,    32'd0, 11'd0, 11'd0}},
            '{OP_GET,    POS_TOP,  32'd0,        1'b1, '{ST_RANGE, 32'd0, 11'd0, 11'd0}},
            '{OP_APPEND, 11'd0,    32'h7FFF_FFFF, 1'b0, '0},
            '{OP_GET,    11'd0,    32'd0,        1'b0, '0},
            '{OP_CLEAR,  11'd0,    32'd0,        1'b1, '{ST_OK,    32'd0, 11'd0, 11'd0}}
        };

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        // directed table
        foreach (directed_rows[i])
            send_request(directed_rows[i].opcode, directed_rows[i].pos,
                         directed_rows[i].elem, directed_rows[i].typed,
                         directed_rows[i].want);

        // random list traffic around a drifting target length
        len_goal = 8;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 40 == 0)
                len_goal = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(0, 48);
            if (n == 100)
                hold_rx_req = 1'b1;
            if (n == 150)
                no_idle = 1'b1;
            if (n == 230)
                no_idle = 1'b0;
            if (n == 320)
                drain_responses();

            r    = $urandom_range(0, 99);
            elem = pick_element();
            pos  = '0;
            if (r < 24)
            begin
                // get or set, mostly in range
                op = (r < 14) ? OP_GET : OP_SET;
                if (shadow_len == 0 || $urandom_range(0, 99) < 15)
                    pos = 11'($urandom_range(shadow_len, 1024));
                else
                    pos = 11'($urandom_range(0, shadow_len - 1));
            end
            else if (r < 26)
                op = OP_CLEAR;
            else if (r < 28)
                op = $urandom_range(0, 1) ? OP_SPARE7 : OP_SPARE6;
            else if (shadow_len < len_goal)
            begin
                if ($urandom_range(0, 99) < 55)
                    op = OP_APPEND;
                else
                begin
                    op = OP_INSERT;
                    if ($urandom_range(0, 99) < 10)
                        pos = 11'($urandom_range(shadow_len + 1, 1024));
                    else
                        pos = 11'($urandom_range(0, shadow_len));
                end
            end
            else
                op = OP_POP;
            send_request(op, pos, elem, 1'b0, '0);
        end

        drain_responses();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d request beats sent (directed table, random traffic), %0d responses checked",
                 beats_sent, rsp_checked);
        $display("list length peaked at %0d, %0d mismatches", peak_len, mismatches);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
sv/glcap_pkg.sv
sv/glcap_cell.sv
sv/glcap_policy.sv
sv/growable_list_with_capacity_policy.sv
tb/tb_top.sv
